@@ hdl/htc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types of the heartbeat takeover controller.
package htc_pkg;

	// Counter width of the silent and fence attempt counters.
	localparam int COUNT_BITS = 8;
	localparam int LIMIT_BITS = 8;
	localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
	localparam int STATUS_BITS = 16;
	localparam int CFG_ADDR_BITS = 8;
	localparam int RES_DEPTH = 3;

	// Control states.
	localparam logic [2:0] ST_ARMED        = 3'd0;
	localparam logic [2:0] ST_SUSPECT      = 3'd1;
	localparam logic [2:0] ST_FENCING      = 3'd2;
	localparam logic [2:0] ST_FENCE_FAILED = 3'd3;
	localparam logic [2:0] ST_FENCED       = 3'd4;
	localparam logic [2:0] ST_TAKEN_OVER   = 3'd5;

	// Event kinds.
	localparam logic [1:0] MODE_ALIVE   = 2'd0;
	localparam logic [1:0] MODE_SILENT  = 2'd1;
	localparam logic [1:0] MODE_REQUEST = 2'd2;
	localparam logic [1:0] MODE_NONE    = 2'd3;

	// Operation mask bits.
	localparam logic [3:0] OP_FENCE    = 4'b0001;
	localparam logic [3:0] OP_ADOPT    = 4'b0010;
	localparam logic [3:0] OP_PRESERVE = 4'b0100;
	localparam logic [3:0] OP_REAP     = 4'b1000;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_BITS-1:0] REG_SILENCE_LIMIT = 8'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_RETRY_LIMIT   = 8'd1;

	localparam logic [LIMIT_BITS-1:0] SILENCE_LIMIT_RST = 8'd3;
	localparam logic [LIMIT_BITS-1:0] RETRY_LIMIT_RST   = 8'd1;

	typedef struct packed {
		logic [1:0]                    mode;
		logic signed [STATUS_BITS-1:0] fence_status;
		logic signed [STATUS_BITS-1:0] adopt_status;
		logic signed [STATUS_BITS-1:0] preserve_status;
		logic signed [STATUS_BITS-1:0] reap_status;
	} evt_item_t;

	typedef struct packed {
		logic [2:0]                    new_state;
		logic [3:0]                    ops_done;
		logic signed [STATUS_BITS-1:0] error_seen;
	} res_item_t;

endpackage

@@ hdl/htc_evt_if.sv @@
`timescale 1ns / 1ps
// Event request channel of the heartbeat takeover controller.
interface htc_evt_if;
	import htc_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [1:0]                    mode;
	logic signed [STATUS_BITS-1:0] fence_status;
	logic signed [STATUS_BITS-1:0] adopt_status;
	logic signed [STATUS_BITS-1:0] preserve_status;
	logic signed [STATUS_BITS-1:0] reap_status;

	modport source (output valid, mode, fence_status, adopt_status, preserve_status,
		reap_status, input ready);
	modport sink (input valid, mode, fence_status, adopt_status, preserve_status,
		reap_status, output ready);
endinterface

@@ hdl/htc_res_if.sv @@
`timescale 1ns / 1ps
// Result request channel of the heartbeat takeover controller.
interface htc_res_if;
	import htc_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [2:0]                    new_state;
	logic [3:0]                    ops_done;
	logic signed [STATUS_BITS-1:0] error_seen;
	logic                          last_of_run;

	modport source (output valid, new_state, ops_done, error_seen, last_of_run,
		input ready);
	modport sink (input valid, new_state, ops_done, error_seen, last_of_run,
		output ready);
endinterface

@@ hdl/htc_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel of the heartbeat takeover controller.
interface htc_cfg_if;
	import htc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CFG_ADDR_BITS-1:0] addr;
	logic [LIMIT_BITS-1:0]    data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

@@ hdl/heartbeat_takeover_controller_top.sv @@
`timescale 1ns / 1ps
// Heartbeat takeover controller: watches a partner and runs fence, adopt, preserve, reap.
//
// Each event request on evt is registered, then decoded in a single pass of
// combinational logic against the control state, giving up to three state-change
// results (armed or suspect, or fencing, fence failed or fenced, taken over) and the next state.
// The results of one event are loaded together into a three-entry result buffer
// that drains one request per cycle on res while res is ready; last_of_run marks the final one.
// Events that yield zero or one result may arrive back to back while res is ready;
// otherwise the results (at most three) hold the result buffer and the next event is
// committed in the cycle its last result leaves. An accepted event is registered in
// the input stage, then its results in the result buffer, before res offers them.
// Silent and fence attempt counters saturate at all ones. Configuration writes
// (register 0 silence limit, 1 retry limit) are taken every cycle and should
// only be issued while no event is in flight.
module heartbeat_takeover_controller_top (
	input logic clk,
	input logic arst_n,
	htc_evt_if.sink evt,
	htc_res_if.source res,
	htc_cfg_if.sink cfg
);
	import htc_pkg::*;

	// Configuration registers
	logic [LIMIT_BITS-1:0] silence_limit_q;
	logic [LIMIT_BITS-1:0] retry_limit_q;

	// Control state
	logic [2:0]                    state_q;
	logic [COUNT_BITS-1:0]         silent_q;
	logic [COUNT_BITS-1:0]         attempt_q;
	logic signed [STATUS_BITS-1:0] err_q;

	// Input stage
	logic      valid_s1;
	evt_item_t item_s1;

	// Result buffer
	res_item_t res_q [RES_DEPTH];
	logic [1:0] res_n_q;
	logic [1:0] res_idx_q;

	// Decode outputs
	res_item_t                     r_w [RES_DEPTH];
	logic [1:0]                    n_w;
	logic [2:0]                    nxt_state;
	logic [COUNT_BITS-1:0]         nxt_silent;
	logic [COUNT_BITS-1:0]         nxt_attempt;
	logic signed [STATUS_BITS-1:0] nxt_err;

	logic [COUNT_BITS-1:0] silent_inc;
	logic [COUNT_BITS-1:0] attempt_inc;
	logic                  fence_ok, adopt_ok, pres_ok;
	logic [3:0]            go_ops;
	logic signed [STATUS_BITS-1:0] go_err;
	logic                  do_start, do_goon;

	logic res_busy, last_take, batch_free, commit;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_limit_q <= SILENCE_LIMIT_RST;
			retry_limit_q   <= RETRY_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_SILENCE_LIMIT: silence_limit_q <= cfg.data;
				REG_RETRY_LIMIT:   retry_limit_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on once the result buffer is free or
	// is handing over its last entry this cycle.
	assign res_busy   = (res_idx_q < res_n_q);
	assign last_take  = res_busy && res.ready && (res_idx_q == res_n_q - 2'd1);
	assign batch_free = !res_busy || last_take;
	assign commit     = valid_s1 && batch_free;
	assign evt.ready  = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			item_s1.mode            <= evt.mode;
			item_s1.fence_status    <= evt.fence_status;
			item_s1.adopt_status    <= evt.adopt_status;
			item_s1.preserve_status <= evt.preserve_status;
			item_s1.reap_status     <= evt.reap_status;
		end
	end

	// Single-pass decode
	assign silent_inc  = (silent_q == '1) ? silent_q : silent_q + 1'b1;
	assign attempt_inc = (attempt_q == '1) ? attempt_q : attempt_q + 1'b1;
	assign fence_ok    = (item_s1.fence_status == '0);
	assign adopt_ok    = (item_s1.adopt_status == '0);
	assign pres_ok     = (item_s1.preserve_status == '0);
	// adopt, preserve and the optional reap
	assign go_ops = OP_ADOPT | OP_PRESERVE | (pres_ok ? OP_REAP : 4'b0000);
	assign go_err = !adopt_ok ? item_s1.adopt_status
		: (!pres_ok ? item_s1.preserve_status : item_s1.reap_status);

	always_comb begin
		do_start    = 1'b0;
		do_goon     = 1'b0;
		nxt_state   = state_q;
		nxt_silent  = silent_q;
		nxt_attempt = attempt_q;
		nxt_err     = err_q;
		n_w         = 2'd0;
		for (int i = 0; i < RES_DEPTH; i++) begin
			r_w[i] = '{new_state: ST_ARMED, ops_done: 4'b0000, error_seen: err_q};
		end

		unique case (state_q)
			ST_ARMED, ST_SUSPECT: begin
				unique case (item_s1.mode)
					MODE_ALIVE: begin
						nxt_silent = '0;
						nxt_state  = ST_ARMED;
						if (state_q == ST_SUSPECT) begin
							r_w[0].new_state = ST_ARMED;
							n_w = 2'd1;
						end
					end
					MODE_SILENT: begin
						nxt_silent = silent_inc;
						if (CMP_BITS'(silent_inc) >= CMP_BITS'(silence_limit_q)) begin
							do_start = 1'b1;
						end else begin
							nxt_state = ST_SUSPECT;
							if (state_q == ST_ARMED) begin
								r_w[0].new_state = ST_SUSPECT;
								n_w = 2'd1;
							end
						end
					end
					MODE_REQUEST: do_start = 1'b1;
					MODE_NONE: ;
					default: ;
				endcase
			end
			ST_FENCE_FAILED: begin
				if ((item_s1.mode == MODE_SILENT || item_s1.mode == MODE_REQUEST) &&
						CMP_BITS'(attempt_q) <= CMP_BITS'(retry_limit_q)) begin
					do_start = 1'b1;
				end
			end
			ST_FENCED: begin
				if (item_s1.mode != MODE_NONE) begin
					do_goon = 1'b1;
				end
			end
			default: ;
		endcase

		if (do_start) begin
			// fencing, then fence failed or fenced, then maybe taken over
			r_w[0]      = '{new_state: ST_FENCING, ops_done: 4'b0000, error_seen: err_q};
			nxt_attempt = attempt_inc;
			if (!fence_ok) begin
				r_w[1]    = '{new_state: ST_FENCE_FAILED, ops_done: OP_FENCE,
					error_seen: item_s1.fence_status};
				n_w       = 2'd2;
				nxt_state = ST_FENCE_FAILED;
				nxt_err   = item_s1.fence_status;
			end else begin
				r_w[1]  = '{new_state: ST_FENCED, ops_done: OP_FENCE,
					error_seen: item_s1.fence_status};
				nxt_err = go_err;
				if (!adopt_ok) begin
					n_w       = 2'd2;
					nxt_state = ST_FENCED;
				end else begin
					r_w[2]    = '{new_state: ST_TAKEN_OVER, ops_done: OP_FENCE | go_ops,
						error_seen: go_err};
					n_w       = 2'd3;
					nxt_state = ST_TAKEN_OVER;
				end
			end
		end else if (do_goon) begin
			nxt_err = go_err;
			if (adopt_ok) begin
				r_w[0]    = '{new_state: ST_TAKEN_OVER, ops_done: go_ops, error_seen: go_err};
				n_w       = 2'd1;
				nxt_state = ST_TAKEN_OVER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_ARMED;
			silent_q  <= '0;
			attempt_q <= '0;
			err_q     <= '0;
			res_n_q   <= 2'd0;
			res_idx_q <= 2'd0;
		end else if (commit) begin
			state_q   <= nxt_state;
			silent_q  <= nxt_silent;
			attempt_q <= nxt_attempt;
			err_q     <= nxt_err;
			res_n_q   <= n_w;
			res_idx_q <= 2'd0;
		end else if (res.valid && res.ready) begin
			res_idx_q <= res_idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			for (int i = 0; i < RES_DEPTH; i++) begin
				res_q[i] <= r_w[i];
			end
		end
	end

	// Output mux
	res_item_t res_cur;
	always_comb begin
		unique case (res_idx_q)
			2'd0:    res_cur = res_q[0];
			2'd1:    res_cur = res_q[1];
			default: res_cur = res_q[2];
		endcase
	end

	assign res.valid       = res_busy;
	assign res.new_state   = res_cur.new_state;
	assign res.ops_done    = res_cur.ops_done;
	assign res.error_seen  = res_cur.error_seen;
	assign res.last_of_run = (res_idx_q == res_n_q - 2'd1);

	// Checks
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(res_n_q <= 2'd3) && (res_idx_q <= res_n_q))
		else $error("result buffer count out of range");

	a_state_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && n_w != 2'd0) |=> (state_q == $past(r_w[n_w - 2'd1].new_state)))
		else $error("control state differs from last emitted result");

	a_fenced_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.new_state == ST_FENCED) |->
			(res.ops_done == OP_FENCE && res.error_seen == '0))
		else $error("fenced result carries a fence failure");

	a_fail_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.new_state == ST_FENCE_FAILED) |->
			(res.ops_done == OP_FENCE && res.error_seen != '0))
		else $error("fence failed result without failure status");

	a_taken_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.new_state == ST_TAKEN_OVER) |->
			((res.ops_done & (OP_ADOPT | OP_PRESERVE)) == (OP_ADOPT | OP_PRESERVE)))
		else $error("taken over without adopt and preserve");

endmodule
